>>> rtl/core/pbg_pkg.sv
// Shared types and constants for the procedural blend gradient pipeline.
package pbg_pkg;

   localparam int VAL_W       = 16;
   localparam int CORDIC_W    = 36;
   localparam int ACC_W       = 34;
   localparam int SQRT_IN_W   = 30;
   localparam int SQRT_STEPS  = 15;
   localparam int SQ_W        = 31;
   localparam int EASE_W      = 17;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int TURN_STEPS  = 24;

   localparam logic [VAL_W-1:0]         VAL_FULL    = 16'd32768;
   localparam logic [EASE_W-1:0]        EASE_SCALE  = 17'd98304;
   localparam logic signed [ACC_W-1:0]  ACC_QUARTER = 34'sh0_4000_0000;
   localparam logic signed [ACC_W-1:0]  ACC_HALF    = 34'sh0_8000_0000;
   localparam logic signed [35:0]       RAD_BIAS    = 36'sh0_8001_0000;
   localparam logic signed [35:0]       RAD_MAX     = 36'sh0_0000_8000;

   // Register index, taken from the word address bit
   localparam logic REG_BLEND_MODE = 1'b0;
   localparam logic REG_FLIP_AXES  = 1'b1;

   typedef enum logic [2:0] {
      MODE_LINEAR    = 3'd0,
      MODE_QUADRATIC = 3'd1,
      MODE_EASING    = 3'd2,
      MODE_DIAGONAL  = 3'd3,
      MODE_SPHERICAL = 3'd4,
      MODE_QUAD_SPH  = 3'd5,
      MODE_RADIAL    = 3'd6
   } blend_mode_type;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] TURN_TABLE [TURN_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // One slot of the shared square-root / CORDIC section
   typedef struct packed {
      logic [2:0]                 mode;
      logic [VAL_W-1:0]           lin;
      logic [VAL_W-1:0]           diag;
      logic                       sat;
      logic [SQRT_IN_W-1:0]       rem;
      logic [SQRT_IN_W-1:0]       root;
      logic signed [CORDIC_W-1:0] cx;
      logic signed [CORDIC_W-1:0] cy;
      logic signed [ACC_W-1:0]    acc;
      logic                       axis;
   } mid_type;

endpackage

>>> rtl/core/procedural_blend_gradient.sv
// Procedural blend gradient: one 3D point in, one gradient value out, fully pipelined.
// The pipeline depth is set by the square-root and CORDIC section, which runs one step per stage.
// Throughput: one request per cycle; a stalled output only halts stages that are full,
// so bubbles collapse while the result waits.
// Reset (synchronous, active high) clears blend_mode, flip_axes and all valid bits.
module procedural_blend_gradient #(
   parameter int COORD_FRAC_BITS = 12,
   parameter int ANGLE_STAGES    = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [15:0]                  req_coord_x,
   input  logic signed [15:0]                  req_coord_y,
   input  logic signed [15:0]                  req_coord_z,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pbg_pkg::VAL_W-1:0]           rsp_blend_value,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pbg_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [pbg_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [pbg_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   // Shared section length: square root and CORDIC run side by side
   localparam int K  = (ANGLE_STAGES > pbg_pkg::SQRT_STEPS) ? ANGLE_STAGES
                                                           : pbg_pkg::SQRT_STEPS;
   localparam int D  = K + 6;
   localparam int F  = COORD_FRAC_BITS;
   localparam int ONE = 1 << F;
   // Signed widths of the linear and diagonal offsets
   localparam int UW = ((F + 1 > 16) ? F + 1 : 16) + 1;
   localparam int VW = ((F + 2 > 17) ? F + 2 : 17) + 1;
   // Bring x^2+y^2+z^2 to 30 fractional bits before the root
   localparam int SH_L = (2 * F <= 30) ? 30 - 2 * F : 0;
   localparam int SH_R = (2 * F > 30) ? 2 * F - 30 : 0;
   localparam int SHW  = 32 + SH_L;

   localparam int P0 = K + 3;
   localparam int P1 = K + 4;
   localparam int P2 = K + 5;

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   logic [2:0] blend_mode_ff;
   logic       flip_axes_ff;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff <= 3'd0;
         flip_axes_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (paddr[2])
            pbg_pkg::REG_BLEND_MODE: blend_mode_ff <= pwdata[2:0];
            pbg_pkg::REG_FLIP_AXES:  flip_axes_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         pbg_pkg::REG_BLEND_MODE: prdata = {29'd0, blend_mode_ff};
         pbg_pkg::REG_FLIP_AXES:  prdata = {31'd0, flip_axes_ff};
         default:                 prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Stage flow control: a stage loads when it is empty or its successor loads,
   // so bubbles collapse and a stall only holds the full stages.
   // ---------------------------------------------------------------------------------
   logic [D-1:0] vld_ff;
   logic [D-1:0] stage_load;

   always_comb begin
      stage_load[D-1] = !vld_ff[D-1] || !rsp_stall;
      for (int k = D - 2; k >= 0; k--) begin
         stage_load[k] = !vld_ff[k] || stage_load[k+1];
      end
   end

   assign req_stall = !stage_load[0];
   assign rsp_valid = vld_ff[D-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_load[0]) vld_ff[0] <= req_valid;
         for (int k = 1; k < D; k++) begin
            if (stage_load[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 0: capture the request, apply the axis swap and snapshot the mode
   // ---------------------------------------------------------------------------------
   logic signed [15:0] a0_ff, b0_ff, z0_ff;
   logic [2:0]         mode0_ff;

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         a0_ff    <= flip_axes_ff ? req_coord_y : req_coord_x;
         b0_ff    <= flip_axes_ff ? req_coord_x : req_coord_y;
         z0_ff    <= req_coord_z;
         mode0_ff <= blend_mode_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 1: squares, linear and diagonal ramps, CORDIC pre-rotation
   // ---------------------------------------------------------------------------------
   logic signed [31:0]                   sqa_in, sqb_in, sqz_in;
   logic signed [UW-1:0]                 u_in;
   logic signed [VW-1:0]                 v_in;
   logic [F+14:0]                        lin_wide;
   logic [F+15:0]                        diag_wide;
   logic [pbg_pkg::VAL_W-1:0]            lin_in, diag_in;
   logic signed [pbg_pkg::CORDIC_W-1:0]  ax_in, by_in, cx_in, cy_in;
   logic signed [pbg_pkg::ACC_W-1:0]     acc_in;
   logic                                 axis_in;

   logic [pbg_pkg::SQ_W-1:0]             sqa1_ff, sqb1_ff, sqz1_ff;
   logic [pbg_pkg::VAL_W-1:0]            lin1_ff, diag1_ff;
   logic signed [pbg_pkg::CORDIC_W-1:0]  cx1_ff, cy1_ff;
   logic signed [pbg_pkg::ACC_W-1:0]     acc1_ff;
   logic                                 axis1_ff;
   logic [2:0]                           mode1_ff;

   always_comb begin
      sqa_in = a0_ff * a0_ff;
      sqb_in = b0_ff * b0_ff;
      sqz_in = z0_ff * z0_ff;

      // linear: (a + 1) over two units, clipped
      u_in     = UW'(a0_ff) + UW'(ONE);
      lin_wide = ((F + 15)'(u_in[F:0]) << 14) >> F;
      if (u_in <= 0)            lin_in = '0;
      else if (u_in >= 2 * ONE) lin_in = pbg_pkg::VAL_FULL;
      else                      lin_in = lin_wide[pbg_pkg::VAL_W-1:0];

      // diagonal: (a + b + 2) over four units, clipped
      v_in      = VW'(a0_ff) + VW'(b0_ff) + VW'(2 * ONE);
      diag_wide = ((F + 16)'(v_in[F+1:0]) << 13) >> F;
      if (v_in <= 0)            diag_in = '0;
      else if (v_in >= 4 * ONE) diag_in = pbg_pkg::VAL_FULL;
      else                      diag_in = diag_wide[pbg_pkg::VAL_W-1:0];

      // radial: scale up, rotate left half-plane points a quarter turn into the right half-plane
      ax_in   = pbg_pkg::CORDIC_W'(a0_ff) <<< 16;
      by_in   = pbg_pkg::CORDIC_W'(b0_ff) <<< 16;
      cx_in   = ax_in;
      cy_in   = by_in;
      acc_in  = '0;
      axis_in = (b0_ff == 16'sd0);
      if (axis_in) begin
         acc_in = a0_ff[15] ? pbg_pkg::ACC_HALF : '0;
      end else if (a0_ff[15]) begin
         if (!b0_ff[15]) begin
            cx_in  = by_in;
            cy_in  = -ax_in;
            acc_in = pbg_pkg::ACC_QUARTER;
         end else begin
            cx_in  = -by_in;
            cy_in  = ax_in;
            acc_in = -pbg_pkg::ACC_QUARTER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[1]) begin
         sqa1_ff  <= sqa_in[pbg_pkg::SQ_W-1:0];
         sqb1_ff  <= sqb_in[pbg_pkg::SQ_W-1:0];
         sqz1_ff  <= sqz_in[pbg_pkg::SQ_W-1:0];
         lin1_ff  <= lin_in;
         diag1_ff <= diag_in;
         cx1_ff   <= cx_in;
         cy1_ff   <= cy_in;
         acc1_ff  <= acc_in;
         axis1_ff <= axis_in;
         mode1_ff <= mode0_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 2: sum of squares, align to 30 fractional bits, flag radius >= 1
   // ---------------------------------------------------------------------------------
   logic [31:0]      sum_in;
   logic [SHW-1:0]   sum_sh;
   pbg_pkg::mid_type mid0_in;
   pbg_pkg::mid_type mid_ff [0:K];

   always_comb begin
      sum_in = 32'(sqa1_ff) + 32'(sqb1_ff) + 32'(sqz1_ff);
      sum_sh = (SHW'(sum_in) << SH_L) >> SH_R;

      mid0_in.mode = mode1_ff;
      mid0_in.lin  = lin1_ff;
      mid0_in.diag = diag1_ff;
      mid0_in.sat  = |sum_sh[SHW-1:pbg_pkg::SQRT_IN_W];
      mid0_in.rem  = sum_sh[pbg_pkg::SQRT_IN_W-1:0];
      mid0_in.root = '0;
      mid0_in.cx   = cx1_ff;
      mid0_in.cy   = cy1_ff;
      mid0_in.acc  = acc1_ff;
      mid0_in.axis = axis1_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_load[2]) mid_ff[0] <= mid0_in;
   end

   // ---------------------------------------------------------------------------------
   // Shared section: at most one root digit and one CORDIC micro-rotation per stage
   // ---------------------------------------------------------------------------------
   for (genvar j = 0; j < K; j++) begin : g_step
      localparam int BIT_POS = (j < pbg_pkg::SQRT_STEPS) ? 28 - 2 * j : 0;
      localparam int TURN_IX = (j < pbg_pkg::TURN_STEPS) ? j : 0;

      pbg_pkg::mid_type                     step_in;
      logic [pbg_pkg::SQRT_IN_W-1:0]        root_bit;
      logic [pbg_pkg::SQRT_IN_W:0]          trial;
      logic signed [pbg_pkg::CORDIC_W-1:0]  dx, dy;
      logic signed [pbg_pkg::ACC_W-1:0]     turn;

      always_comb begin
         step_in  = mid_ff[j];
         root_bit = pbg_pkg::SQRT_IN_W'(1) << BIT_POS;
         trial    = (pbg_pkg::SQRT_IN_W + 1)'(mid_ff[j].root)
                  + (pbg_pkg::SQRT_IN_W + 1)'(root_bit);
         dx       = mid_ff[j].cy >>> j;
         dy       = mid_ff[j].cx >>> j;
         turn     = pbg_pkg::ACC_W'(pbg_pkg::TURN_TABLE[TURN_IX]);

         if (j < pbg_pkg::SQRT_STEPS) begin
            if ((pbg_pkg::SQRT_IN_W + 1)'(mid_ff[j].rem) >= trial) begin
               step_in.rem  = mid_ff[j].rem - trial[pbg_pkg::SQRT_IN_W-1:0];
               step_in.root = (mid_ff[j].root >> 1) + root_bit;
            end else begin
               step_in.root = mid_ff[j].root >> 1;
            end
         end

         // steer y toward zero; axis points keep their fixed angle
         if (j < ANGLE_STAGES && !mid_ff[j].axis) begin
            if (!mid_ff[j].cy[pbg_pkg::CORDIC_W-1]) begin
               step_in.cx  = mid_ff[j].cx + dx;
               step_in.cy  = mid_ff[j].cy - dy;
               step_in.acc = mid_ff[j].acc + turn;
            end else begin
               step_in.cx  = mid_ff[j].cx - dx;
               step_in.cy  = mid_ff[j].cy + dy;
               step_in.acc = mid_ff[j].acc - turn;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (stage_load[j+3]) mid_ff[j+1] <= step_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Post stage 0: sphere and radial values, pick the base value for the mode
   // ---------------------------------------------------------------------------------
   logic [pbg_pkg::VAL_W-1:0] sph_in, rad_in, base_in;
   logic signed [35:0]        turn_sum;
   logic signed [35:0]        turn_q;
   logic [pbg_pkg::VAL_W-1:0] p0_val_ff;
   logic [2:0]                p0_mode_ff;

   always_comb begin
      if (mid_ff[K].sat) sph_in = '0;
      else sph_in = pbg_pkg::VAL_FULL
                  - pbg_pkg::VAL_W'(mid_ff[K].root[pbg_pkg::SQRT_STEPS-1:0]);

      // angle in turns, shifted to 0..1 with rounding to 2^-15
      turn_sum = 36'(mid_ff[K].acc) + pbg_pkg::RAD_BIAS;
      turn_q   = turn_sum >>> 17;
      if (turn_sum <= 0)                   rad_in = '0;
      else if (turn_q > pbg_pkg::RAD_MAX)  rad_in = pbg_pkg::VAL_FULL;
      else                                 rad_in = turn_q[pbg_pkg::VAL_W-1:0];

      unique case (mid_ff[K].mode)
         pbg_pkg::MODE_DIAGONAL:  base_in = mid_ff[K].diag;
         pbg_pkg::MODE_SPHERICAL,
         pbg_pkg::MODE_QUAD_SPH:  base_in = sph_in;
         pbg_pkg::MODE_RADIAL:    base_in = rad_in;
         default:                 base_in = mid_ff[K].lin;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_load[P0]) begin
         p0_val_ff  <= base_in;
         p0_mode_ff <= mid_ff[K].mode;
      end
   end

   // ---------------------------------------------------------------------------------
   // Post stage 1: square the base value, form the easing weight 3 - 2L
   // ---------------------------------------------------------------------------------
   logic [31:0]                sq_in;
   logic [pbg_pkg::SQ_W-1:0]   p1_sq_ff;
   logic [pbg_pkg::EASE_W-1:0] p1_k_ff;
   logic [pbg_pkg::VAL_W-1:0]  p1_val_ff;
   logic [2:0]                 p1_mode_ff;

   assign sq_in = 32'(p0_val_ff) * 32'(p0_val_ff);

   always_ff @(posedge clock) begin
      if (stage_load[P1]) begin
         p1_sq_ff   <= sq_in[pbg_pkg::SQ_W-1:0];
         p1_k_ff    <= pbg_pkg::EASE_SCALE - (pbg_pkg::EASE_W'(p0_val_ff) << 1);
         p1_val_ff  <= p0_val_ff;
         p1_mode_ff <= p0_mode_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Post stage 2: shape by mode, clip, hold in the output register
   // ---------------------------------------------------------------------------------
   logic [47:0]               ease_prod;
   logic [pbg_pkg::VAL_W-1:0] shaped_in, out_in, out_ff;

   always_comb begin
      ease_prod = 48'(p1_sq_ff) * 48'(p1_k_ff);
      unique case (p1_mode_ff)
         pbg_pkg::MODE_QUADRATIC,
         pbg_pkg::MODE_QUAD_SPH:  shaped_in = p1_sq_ff[30:15];
         pbg_pkg::MODE_EASING:    shaped_in = ease_prod[45:30];
         default:                 shaped_in = p1_val_ff;
      endcase
      out_in = (shaped_in > pbg_pkg::VAL_FULL) ? pbg_pkg::VAL_FULL : shaped_in;
   end

   always_ff @(posedge clock) begin
      if (stage_load[P2]) out_ff <= out_in;
   end

   assign rsp_blend_value = out_ff;

endmodule
